/* sv/nfsa_pkg.sv */
package nfsa_pkg;

	localparam int MaxSlots = 256;
	localparam int SlotW    = 8;
	localparam int CountW   = 9;
	localparam int RowBits  = 16;
	localparam int RowIdxW  = $clog2(RowBits);
	localparam int Rows     = MaxSlots / RowBits;
	localparam int RowAddrW = $clog2(Rows);
	localparam int AddrW    = 3;
	localparam int DataW    = 32;

	typedef enum logic [1:0] {
		StatusOk    = 2'd0,
		StatusFull  = 2'd1,
		StatusRange = 2'd2
	} status_t;

	typedef enum logic {
		FuncAlloc = 1'b0,
		FuncFree  = 1'b1
	} func_t;

	// Register index as decoded from bit 2 of the byte address.
	localparam logic RegPoolSize = 1'b0;

	// Pool size as used by the search: zero acts as one, anything above the
	// slot count is clamped to it.
	function automatic logic [CountW-1:0] eff_size(input logic [CountW-1:0] v);
		logic [CountW-1:0] n;
		n = v;
		if (n == '0) begin
			n = CountW'(1);
		end
		if (n > CountW'(MaxSlots)) begin
			n = CountW'(MaxSlots);
		end
		return n;
	endfunction

endpackage

/* sv/next_fit_slot_allocator.sv */
// Next-fit slot allocator over a pool of up to 256 slots.
// Request channel (req_valid/req_stall): func selects allocate or free and
// slot_id names the slot to free. A beat is taken when req_valid is high and
// req_stall is low. Response channel (rsp_valid/rsp_stall): status,
// granted_slot and free_slots, one beat per request, held while stalled.
// The free bitmap sits in a 16 x 16-bit synchronous memory. A request that
// reaches the memory reads a row, checks it and writes back the row it changes.
// A free, or an allocate that hits in its first row, gives its response from
// that row check; an allocate that finds nothing moves on to the next row,
// wrapping, so a rotating search may visit every row of the pool.
// A full pool or an out-of-range free answers from idle, without a read.
// One request is in flight at a time; a new request is taken once the
// response register is free or being emptied.
// Reset, and any write of pool_size over the APB port, mark every slot free
// at once through per-row valid bits, put the search position at slot 0 and
// set the free count to the effective pool size. No clearing sweep is needed.
// While rsp_stall is high the finished response is held; rows may still be searched.
module next_fit_slot_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          func,
	input  logic [nfsa_pkg::SlotW-1:0]    slot_id,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    status,
	output logic [nfsa_pkg::SlotW-1:0]    granted_slot,
	output logic [nfsa_pkg::CountW-1:0]   free_slots,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nfsa_pkg::AddrW-1:0]    paddr,
	input  logic [nfsa_pkg::DataW-1:0]    pwdata,
	output logic [nfsa_pkg::DataW-1:0]    prdata,
	output logic                          pready
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EVAL = 3'b100
	} state_t;

	state_t                                state_q;
	logic [nfsa_pkg::RowBits-1:0]          mem [nfsa_pkg::Rows];
	logic [nfsa_pkg::RowBits-1:0]          rdata_q;
	logic                                  rvld_q;
	logic [nfsa_pkg::Rows-1:0]             row_vld_q;
	logic [nfsa_pkg::RowAddrW-1:0]         row_q;
	logic                                  first_q;
	logic [nfsa_pkg::RowIdxW-1:0]          start_off_q;
	logic                                  func_q;
	logic [nfsa_pkg::SlotW-1:0]            id_q;
	logic [nfsa_pkg::CountW-1:0]           pool_q;
	logic [nfsa_pkg::CountW-1:0]           n_q;
	logic [nfsa_pkg::CountW-1:0]           total_q;
	logic [nfsa_pkg::SlotW-1:0]            start_q;
	logic                                  rsp_valid_q;
	nfsa_pkg::status_t                     status_q;
	logic [nfsa_pkg::SlotW-1:0]            granted_q;
	logic [nfsa_pkg::CountW-1:0]           free_q;

	logic                                  cfg_we;
	logic                                  load_ok;
	logic                                  req_take;
	logic [nfsa_pkg::SlotW-1:0]            start_eff;
	logic [nfsa_pkg::RowBits-1:0]          rowdata;
	logic [nfsa_pkg::RowBits-1:0]          cand;
	logic                                  hit;
	logic [nfsa_pkg::RowIdxW-1:0]          hit_bit;
	logic [nfsa_pkg::CountW-1:0]           hit_pos;
	logic [nfsa_pkg::CountW-1:0]           pos_next;
	logic [nfsa_pkg::CountW-1:0]           row_base_next;
	logic [nfsa_pkg::RowAddrW-1:0]         row_next;
	logic                                  was_free;
	logic                                  mem_we;
	logic [nfsa_pkg::RowBits-1:0]          mem_wdata;

	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite && (paddr[2] == nfsa_pkg::RegPoolSize);
	assign prdata   = (paddr[2] == nfsa_pkg::RegPoolSize) ?
		{{(nfsa_pkg::DataW-nfsa_pkg::CountW){1'b0}}, pool_q} : '0;

	assign load_ok   = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == S_IDLE) && load_ok);
	assign req_take  = req_valid && !req_stall;

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign free_slots   = free_q;

	assign start_eff = ({1'b0, start_q} >= n_q) ? '0 : start_q;

	// Row check: an invalid row has not been written since the pool was
	// cleared, so all its slots are free.
	always_comb begin
		rowdata = rvld_q ? rdata_q : '1;
		for (int b = 0; b < nfsa_pkg::RowBits; b++) begin
			cand[b] = rowdata[b]
				&& ({1'b0, row_q, nfsa_pkg::RowIdxW'(b)} < n_q)
				&& !(first_q && (nfsa_pkg::RowIdxW'(b) < start_off_q));
		end
		hit     = 1'b0;
		hit_bit = '0;
		for (int b = nfsa_pkg::RowBits - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit     = 1'b1;
				hit_bit = nfsa_pkg::RowIdxW'(b);
			end
		end
		hit_pos       = {1'b0, row_q, hit_bit};
		pos_next      = hit_pos + nfsa_pkg::CountW'(1);
		row_base_next = {1'b0, row_q, {nfsa_pkg::RowIdxW{1'b0}}}
			+ nfsa_pkg::CountW'(nfsa_pkg::RowBits);
		row_next      = (row_base_next >= n_q) ? '0 : row_q + nfsa_pkg::RowAddrW'(1);
		was_free      = rowdata[id_q[nfsa_pkg::RowIdxW-1:0]];
		mem_we        = 1'b0;
		mem_wdata     = rowdata;
		if ((state_q == S_EVAL) && load_ok) begin
			if (func_q == nfsa_pkg::FuncAlloc) begin
				mem_we    = hit;
				mem_wdata = rowdata & ~(nfsa_pkg::RowBits'(1) << hit_bit);
			end else begin
				mem_we    = 1'b1;
				mem_wdata = rowdata | (nfsa_pkg::RowBits'(1) << id_q[nfsa_pkg::RowIdxW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[row_q] <= mem_wdata;
		end
		rdata_q <= mem[row_q];
		rvld_q  <= row_vld_q[row_q];
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			func_q <= func;
			id_q   <= slot_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_vld_q   <= '0;
			row_q       <= '0;
			first_q     <= 1'b0;
			start_off_q <= '0;
			pool_q      <= nfsa_pkg::CountW'(nfsa_pkg::MaxSlots);
			n_q         <= nfsa_pkg::CountW'(nfsa_pkg::MaxSlots);
			total_q     <= nfsa_pkg::CountW'(nfsa_pkg::MaxSlots);
			start_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= nfsa_pkg::StatusOk;
			granted_q   <= '0;
			free_q      <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				pool_q    <= pwdata[nfsa_pkg::CountW-1:0];
				n_q       <= nfsa_pkg::eff_size(pwdata[nfsa_pkg::CountW-1:0]);
				total_q   <= nfsa_pkg::eff_size(pwdata[nfsa_pkg::CountW-1:0]);
				start_q   <= '0;
				row_vld_q <= '0;
			end
			if (mem_we) begin
				row_vld_q[row_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						if (func == nfsa_pkg::FuncAlloc) begin
							if (total_q == '0) begin
								rsp_valid_q <= 1'b1;
								status_q    <= nfsa_pkg::StatusFull;
								granted_q   <= '0;
								free_q      <= total_q;
							end else begin
								start_q     <= start_eff;
								row_q       <= start_eff[nfsa_pkg::SlotW-1 -: nfsa_pkg::RowAddrW];
								start_off_q <= start_eff[nfsa_pkg::RowIdxW-1:0];
								first_q     <= 1'b1;
								state_q     <= S_READ;
							end
						end else begin
							if ({1'b0, slot_id} >= n_q) begin
								rsp_valid_q <= 1'b1;
								status_q    <= nfsa_pkg::StatusRange;
								granted_q   <= '0;
								free_q      <= total_q;
							end else begin
								row_q   <= slot_id[nfsa_pkg::SlotW-1 -: nfsa_pkg::RowAddrW];
								first_q <= 1'b0;
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (func_q == nfsa_pkg::FuncAlloc) begin
						if (!hit) begin
							// Nothing free here: move on to the next row, wrapping.
							row_q   <= row_next;
							first_q <= 1'b0;
							state_q <= S_READ;
						end else if (load_ok) begin
							start_q     <= (pos_next >= n_q) ? '0 : pos_next[nfsa_pkg::SlotW-1:0];
							total_q     <= total_q - nfsa_pkg::CountW'(1);
							rsp_valid_q <= 1'b1;
							status_q    <= nfsa_pkg::StatusOk;
							granted_q   <= hit_pos[nfsa_pkg::SlotW-1:0];
							free_q      <= total_q - nfsa_pkg::CountW'(1);
							state_q     <= S_IDLE;
						end
					end else if (load_ok) begin
						rsp_valid_q <= 1'b1;
						status_q    <= nfsa_pkg::StatusOk;
						granted_q   <= '0;
						if (!was_free && (total_q < n_q)) begin
							total_q <= total_q + nfsa_pkg::CountW'(1);
							free_q  <= total_q + nfsa_pkg::CountW'(1);
						end else begin
							free_q  <= total_q;
						end
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int CycleLimit   = 300000;
	localparam int SettleCycles = 40;
	localparam int MaxReported  = 10;
	localparam int PhaseItems   = 40;
	localparam logic [nfsa_pkg::AddrW-1:0] PoolSizeAddr = {nfsa_pkg::RegPoolSize, 2'b00};

	typedef struct {
		nfsa_pkg::status_t           st;
		logic [nfsa_pkg::SlotW-1:0]  slot;
		logic [nfsa_pkg::CountW-1:0] count;
	} slot_reply_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        req_valid = 1'b0;
	logic                        req_stall;
	logic                        func      = nfsa_pkg::FuncAlloc;
	logic [nfsa_pkg::SlotW-1:0]  slot_id   = '0;
	logic                        rsp_valid;
	logic                        rsp_stall = 1'b0;
	logic [1:0]                  status;
	logic [nfsa_pkg::SlotW-1:0]  granted_slot;
	logic [nfsa_pkg::CountW-1:0] free_slots;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [nfsa_pkg::AddrW-1:0]  paddr     = '0;
	logic [nfsa_pkg::DataW-1:0]  pwdata    = '0;
	logic [nfsa_pkg::DataW-1:0]  prdata;
	logic                        pready;

	next_fit_slot_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.slot_id      (slot_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.granted_slot (granted_slot),
		.free_slots   (free_slots),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Shadow of the allocator: free bitmap, next-fit position, free count and register.
	logic                        slot_free [nfsa_pkg::MaxSlots];
	int unsigned                 next_pos;
	int unsigned                 free_count;
	logic [nfsa_pkg::CountW-1:0] pool_reg;

	int          error_count = 0;
	int unsigned cycle_count = 0;
	bit          calm        = 1'b0;
	slot_reply_t expected_replies [$];
	slot_reply_t oldest_reply;

	function automatic int unsigned pool_limit();
		int unsigned n;
		n = pool_reg;
		if (n < 1) begin
			n = 1;
		end
		if (n > nfsa_pkg::MaxSlots) begin
			n = nfsa_pkg::MaxSlots;
		end
		return n;
	endfunction

	function automatic void reset_pool();
		for (int i = 0; i < nfsa_pkg::MaxSlots; i++) begin
			slot_free[i] = 1'b1;
		end
		next_pos   = 0;
		free_count = pool_limit();
	endfunction

	function automatic slot_reply_t predict_request(input nfsa_pkg::func_t f,
			input logic [nfsa_pkg::SlotW-1:0] id);
		slot_reply_t r;
		int unsigned n;
		int unsigned pos;
		int unsigned i;
		bit          found;
		n       = pool_limit();
		r.st    = nfsa_pkg::StatusOk;
		r.slot  = '0;
		found   = 1'b0;
		i       = 0;
		if (next_pos >= n) begin
			next_pos = 0;
		end
		if (f == nfsa_pkg::FuncAlloc) begin
			pos = next_pos;
			while (!found && i < n) begin
				if (slot_free[pos]) begin
					found = 1'b1;
				end else begin
					pos++;
					if (pos >= n) begin
						pos = 0;
					end
					i++;
				end
			end
			if (found) begin
				slot_free[pos] = 1'b0;
				r.slot         = nfsa_pkg::SlotW'(pos);
				next_pos       = (pos + 1 >= n) ? 0 : pos + 1;
				if (free_count > 0) begin
					free_count--;
				end
			end else begin
				r.st = nfsa_pkg::StatusFull;
			end
		end else if (id >= n) begin
			r.st = nfsa_pkg::StatusRange;
		end else if (!slot_free[id]) begin
			slot_free[id] = 1'b1;
			if (free_count < n) begin
				free_count++;
			end
		end
		r.count = nfsa_pkg::CountW'(free_count);
		return r;
	endfunction

	// Random slot that the shadow holds as in use, or -1 when none is.
	function automatic int pick_used_slot();
		int used [$];
		for (int i = 0; i < pool_limit(); i++) begin
			if (!slot_free[i]) begin
				used.push_back(i);
			end
		end
		if (used.size() == 0) begin
			return -1;
		end
		return used[$urandom_range(0, used.size() - 1)];
	endfunction

	function automatic void note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		error_count++;
		if (error_count <= MaxReported) begin
			$display("mismatch in %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_replies.size() == 0) begin
				note_mismatch("reply beat with none outstanding, free_slots", 0, free_slots);
			end else begin
				oldest_reply = expected_replies.pop_front();
				if (status !== oldest_reply.st) begin
					note_mismatch("status", oldest_reply.st, status);
				end
				if (granted_slot !== oldest_reply.slot) begin
					note_mismatch("granted_slot", oldest_reply.slot, granted_slot);
				end
				if (free_slots !== oldest_reply.count) begin
					note_mismatch("free_slots", oldest_reply.count, free_slots);
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(0, 99) < 6);
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Valid stays high from one beat to the next unless an idle gap is drawn.
	task automatic send_request(input nfsa_pkg::func_t f,
			input logic [nfsa_pkg::SlotW-1:0] id);
		if (!calm && $urandom_range(0, 99) < 6) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= f;
		slot_id   <= id;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		expected_replies.push_back(predict_request(f, id));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic apb_xfer(input logic wr, input logic [nfsa_pkg::DataW-1:0] wdata,
			output logic [nfsa_pkg::DataW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PoolSizeAddr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_pool_reg();
		logic [nfsa_pkg::DataW-1:0] rd;
		apb_xfer(1'b0, '0, rd);
		if (rd !== nfsa_pkg::DataW'(pool_reg)) begin
			note_mismatch("pool_size read-back", pool_reg, rd);
		end
	endtask

	task automatic set_pool_size(input logic [nfsa_pkg::DataW-1:0] value);
		logic [nfsa_pkg::DataW-1:0] rd;
		wait_idle();
		apb_xfer(1'b1, value, rd);
		pool_reg = value[nfsa_pkg::CountW-1:0];
		reset_pool();
		check_pool_reg();
	endtask

	task automatic test_reset_values();
		check_pool_reg();
		send_request(nfsa_pkg::FuncAlloc, 8'hFF);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		send_request(nfsa_pkg::FuncFree, 8'd0);
		// A second free of the same slot must leave the count alone.
		send_request(nfsa_pkg::FuncFree, 8'd0);
		send_request(nfsa_pkg::FuncFree, 8'd255);
		send_request(nfsa_pkg::FuncAlloc, 8'h5A);
	endtask

	task automatic test_pool_limits();
		set_pool_size(32'd1);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		send_request(nfsa_pkg::FuncAlloc, 8'hA5);
		send_request(nfsa_pkg::FuncFree, 8'd1);
		send_request(nfsa_pkg::FuncFree, 8'd255);
		send_request(nfsa_pkg::FuncFree, 8'd0);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		// Zero in the low bits behaves as a single slot; the upper bits are ignored.
		set_pool_size(32'hFFFF_FE00);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		send_request(nfsa_pkg::FuncAlloc, 8'hFF);
		set_pool_size(32'h0000_01FF);
		send_request(nfsa_pkg::FuncFree, 8'd255);
		// Three slots: fill, hit full, then the search position, wrapped to slot 0, must find slot 1.
		set_pool_size(32'd3);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
		send_request(nfsa_pkg::FuncFree, 8'd1);
		send_request(nfsa_pkg::FuncAlloc, 8'h00);
	endtask

	task automatic test_random_traffic();
		logic [nfsa_pkg::DataW-1:0] sizes [10];
		int                         r;
		int                         used;
		sizes = '{32'd1, 32'd2, 32'd5, 32'd16, 32'd17, 32'd64, 32'd256, 32'd0, 32'd511,
			32'd0};
		sizes[9] = nfsa_pkg::DataW'($urandom_range(1, 511));
		for (int p = 0; p < 10; p++) begin
			set_pool_size(sizes[p] | ($urandom() & ~32'h1FF));
			calm = (p == 5);
			for (int k = 0; k < PhaseItems; k++) begin
				r    = $urandom_range(0, 99);
				used = pick_used_slot();
				if (r < 55 || (r < 85 && used < 0)) begin
					send_request(nfsa_pkg::FuncAlloc,
						nfsa_pkg::SlotW'($urandom_range(0, 255)));
				end else if (r < 85) begin
					send_request(nfsa_pkg::FuncFree, nfsa_pkg::SlotW'(used));
				end else if (r < 93) begin
					send_request(nfsa_pkg::FuncFree,
						nfsa_pkg::SlotW'($urandom_range(0, pool_limit() - 1)));
				end else begin
					send_request(nfsa_pkg::FuncFree,
						nfsa_pkg::SlotW'($urandom_range(0, 255)));
				end
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		pool_reg = nfsa_pkg::CountW'(nfsa_pkg::MaxSlots);
		reset_pool();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_pool_limits();
		test_random_traffic();
		wait_idle();
		repeat (SettleCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
